// ----- hw/rtl/crc_pkg.sv -----
// Shared types and constants of the crop region calculator.
`timescale 1ns / 1ps
package crc_pkg;
  localparam int unsigned DimBits  = 14;
  localparam int unsigned SkyBits  = 16;
  localparam int unsigned ProdBits = 2 * DimBits;
  localparam int unsigned TolInv   = 1000;
  localparam int unsigned QDepth   = 2;

  typedef enum logic [1:0] {
    CfgTargetW = 2'd0,
    CfgTargetH = 2'd1,
    CfgSky     = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [DimBits-1:0] sw;
    logic [DimBits-1:0] sh;
    logic               zero;
  } job_t;
endpackage

// ----- hw/rtl/crop_region_calculator.sv -----
// Top level of the crop region calculator.
`timescale 1ns / 1ps
// Usage:
//   Input: source_width_i/source_height_i transfer when start is high and
//   busy is low. A two-entry job queue decouples the accepting front from the
//   computing back end; busy rises only while both entries are taken.
//   Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
//   index 0 target width, 1 target height, 2 sky fraction; others ignored.
//   Write only while idle. cfg_ready_o is always high.
//   Output: one result per item, shown for a single cycle with result_valid_o;
//   the receiver cannot stall.
//   A zero dimension goes from the queue straight to the output state; otherwise
//   up to two aspect divisions run, each holding the shared restoring divider
//   for its 28 quotient bits, so the back end finishes one item before it takes
//   the next; queued items wait their turn.
//   Reset: queue empties, sequencer idles, targets go to 1, sky fraction to 0.
module crop_region_calculator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [crc_pkg::DimBits-1:0] source_width_i,
  input  logic [crc_pkg::DimBits-1:0] source_height_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [1:0]                  cfg_index_i,
  input  logic [crc_pkg::SkyBits-1:0] cfg_data_i,
  output logic                        result_valid_o,
  output logic [crc_pkg::DimBits-1:0] region_x_o,
  output logic [crc_pkg::DimBits-1:0] region_y_o,
  output logic [crc_pkg::DimBits-1:0] region_w_o,
  output logic [crc_pkg::DimBits-1:0] region_h_o,
  output logic                        region_valid_o
);
  import crc_pkg::*;
  logic [DimBits-1:0] tw_q, th_q;
  logic [SkyBits-1:0] sky_q;
  logic pop, avail;
  job_t job;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tw_q <= DimBits'(1); th_q <= DimBits'(1); sky_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgTargetW: tw_q  <= cfg_data_i[DimBits-1:0];
        CfgTargetH: th_q  <= cfg_data_i[DimBits-1:0];
        CfgSky:     sky_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  crc_front u_front (.clk_i, .rst_ni, .start_i(start), .source_width_i, .source_height_i,
                     .tw_i(tw_q), .th_i(th_q), .busy_o(busy), .pop_i(pop),
                     .avail_o(avail), .job_o(job));

  crc_back u_back (.clk_i, .rst_ni, .avail_i(avail), .job_i(job), .pop_o(pop),
                   .tw_i(tw_q), .th_i(th_q), .sky_i(sky_q), .valid_o(result_valid_o),
                   .region_x_o, .region_y_o, .region_w_o, .region_h_o, .region_valid_o);
endmodule

// ----- hw/rtl/crc_divider.sv -----
// Restoring divider with half-to-even rounding, one quotient bit per cycle.
`timescale 1ns / 1ps
module crc_divider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [crc_pkg::ProdBits-1:0]  num_i,
  input  logic [crc_pkg::DimBits-1:0]   den_i,
  output logic                          done_o,
  output logic [crc_pkg::ProdBits-1:0]  quo_o
);
  import crc_pkg::*;
  localparam int unsigned CntBits = $clog2(ProdBits + 1);
  logic [ProdBits-1:0] num_q, num_d, quo_q, quo_d;
  logic [DimBits:0]    rem_q, rem_d, trial;
  logic [DimBits-1:0]  den_q;
  logic [CntBits-1:0]  cnt_q, cnt_d;
  logic                busy_q, busy_d, done_q, done_d;
  logic [DimBits+1:0]  r2;
  logic                up;

  always_comb begin
    num_d = num_q; quo_d = quo_q; rem_d = rem_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    trial = {rem_q[DimBits-1:0], num_q[ProdBits-1]};
    if (start_i) begin
      num_d = num_i; quo_d = '0; rem_d = '0; busy_d = 1'b1;
      cnt_d = CntBits'(ProdBits);
    end else if (busy_q) begin
      num_d = {num_q[ProdBits-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[ProdBits-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[ProdBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; quo_q <= quo_d; rem_q <= rem_d;
    if (start_i) den_q <= den_i;
  end

  assign r2    = {rem_q, 1'b0};
  assign up    = (r2 > {1'b0, den_q, 1'b0} >> 1) || (r2 == {2'b0, den_q} && quo_q[0]);
  assign done_o = done_q;
  assign quo_o  = quo_q + ProdBits'(up);
endmodule

// ----- hw/rtl/crc_front.sv -----
// Front end: accepts sizes, flags zero dimensions, queues jobs.
`timescale 1ns / 1ps
module crc_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [crc_pkg::DimBits-1:0] source_width_i,
  input  logic [crc_pkg::DimBits-1:0] source_height_i,
  input  logic [crc_pkg::DimBits-1:0] tw_i,
  input  logic [crc_pkg::DimBits-1:0] th_i,
  output logic                      busy_o,
  input  logic                      pop_i,
  output logic                      avail_o,
  output crc_pkg::job_t             job_o
);
  import crc_pkg::*;
  job_t       mem_q [QDepth];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push;
  job_t       jin;

  assign busy_o  = (cnt_q == 2'(QDepth));
  assign push    = start_i && !busy_o;
  assign avail_o = (cnt_q != 2'd0);
  assign job_o   = mem_q[rp_q];
  assign jin.sw  = source_width_i;
  assign jin.sh  = source_height_i;
  assign jin.zero = (source_width_i == '0) || (source_height_i == '0) ||
                    (tw_i == '0) || (th_i == '0);

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= jin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop_i);
    end
  end
endmodule

// ----- hw/rtl/crc_back.sv -----
// Back end: sequencer for crop, sky removal and aspect restore.
`timescale 1ns / 1ps
module crc_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        avail_i,
  input  crc_pkg::job_t               job_i,
  output logic                        pop_o,
  input  logic [crc_pkg::DimBits-1:0] tw_i,
  input  logic [crc_pkg::DimBits-1:0] th_i,
  input  logic [crc_pkg::SkyBits-1:0] sky_i,
  output logic                        valid_o,
  output logic [crc_pkg::DimBits-1:0] region_x_o,
  output logic [crc_pkg::DimBits-1:0] region_y_o,
  output logic [crc_pkg::DimBits-1:0] region_w_o,
  output logic [crc_pkg::DimBits-1:0] region_h_o,
  output logic                        region_valid_o
);
  import crc_pkg::*;
  typedef enum logic [9:0] {
    StIdle = 10'b0000000001, StMulA = 10'b0000000010, StCmp1 = 10'b0000000100,
    StDiv1 = 10'b0000001000, StSky  = 10'b0000010000, StTop  = 10'b0000100000,
    StMulB = 10'b0001000000, StDiv2 = 10'b0010000000, StWait = 10'b0100000000,
    StOut  = 10'b1000000000
  } state_e;
  localparam int unsigned SkyProd = DimBits + SkyBits;
  localparam int unsigned TolBits = ProdBits + 10;

  state_e state_q, state_d;
  logic [DimBits-1:0]  x_q, y_q, w_q, h_q, x_d, y_d, w_d, h_d;
  logic                zero_q, zero_d, wide_q, wide_d;
  logic [ProdBits-1:0] a_q, b_q, hth_q, a_d, b_d, hth_d;
  logic [SkyProd-1:0]  sp_q, sp_d;
  logic                phase2_q, phase2_d;
  logic [ProdBits-1:0] diff;
  logic [TolBits-1:0]  difft;
  logic                dstart, ddone;
  logic [ProdBits-1:0] dnum, dquo;
  logic [DimBits-1:0]  dden, nv;
  logic [SkyBits-1:0]  frac;
  logic [DimBits:0]    topr;
  logic [DimBits-1:0]  top;
  logic                sky_up;

  crc_divider u_div (.clk_i, .rst_ni, .start_i(dstart), .num_i(dnum), .den_i(dden),
                     .done_o(ddone), .quo_o(dquo));

  assign diff  = (a_q > b_q) ? a_q - b_q : b_q - a_q;
  // diff * 1000 as 1024 - 16 - 8
  assign difft = (TolBits'(diff) << 10) - (TolBits'(diff) << 4) - (TolBits'(diff) << 3);
  assign nv    = (dquo == '0) ? DimBits'(1) : dquo[DimBits-1:0];
  assign frac  = sp_q[SkyBits-1:0];
  assign sky_up = (frac > {1'b1, {(SkyBits-1){1'b0}}}) ||
                  (frac == {1'b1, {(SkyBits-1){1'b0}}} && sp_q[SkyBits]);
  assign topr  = {1'b0, sp_q[SkyProd-1:SkyBits]} + (DimBits+1)'(sky_up);
  assign top   = (topr > {1'b0, h_q - 1'b1}) ? h_q - 1'b1 : topr[DimBits-1:0];

  always_comb begin
    state_d = state_q; x_d = x_q; y_d = y_q; w_d = w_q; h_d = h_q;
    zero_d = zero_q; wide_d = wide_q; a_d = a_q; b_d = b_q; hth_d = hth_q;
    sp_d = sp_q; phase2_d = phase2_q;
    pop_o = 1'b0; dstart = 1'b0;
    dnum = wide_q ? h_q * tw_i : w_q * th_i;
    dden = wide_q ? th_i : tw_i;
    case (state_q)
      StIdle: if (avail_i) begin
        pop_o = 1'b1;
        x_d = '0; y_d = '0; w_d = job_i.sw; h_d = job_i.sh; zero_d = job_i.zero;
        phase2_d = 1'b0;
        state_d = job_i.zero ? StOut : StMulA;
      end
      StMulA: begin
        a_d = w_q * th_i; b_d = tw_i * h_q; hth_d = h_q * th_i;
        state_d = phase2_q ? StMulB : StCmp1;
      end
      StCmp1: begin
        wide_d = a_q > b_q;
        state_d = (difft >= TolBits'(hth_q)) ? StDiv1 : StSky;
      end
      StDiv1: begin
        dstart = 1'b1; state_d = StWait;
      end
      StWait: if (ddone) begin
        if (wide_q) begin
          x_d = x_q + ((w_q - nv) >> 1); w_d = nv;
        end else if (!phase2_q) begin
          y_d = y_q + ((h_q - nv) >> 1); h_d = nv;
        end else begin
          y_d = y_q + (h_q - nv); h_d = nv;
        end
        state_d = phase2_q ? StOut : StSky;
      end
      StSky: begin
        sp_d = h_q * sky_i; state_d = StTop;
      end
      StTop: begin
        y_d = y_q + top; h_d = h_q - top; phase2_d = 1'b1; state_d = StMulA;
      end
      StMulB: begin
        wide_d = a_q > b_q;
        state_d = (a_q != b_q) ? StDiv2 : StOut;
      end
      StDiv2: begin
        dstart = 1'b1; state_d = StWait;
      end
      StOut: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; w_q <= w_d; h_q <= h_d; zero_q <= zero_d;
    wide_q <= wide_d; a_q <= a_d; b_q <= b_d; hth_q <= hth_d; sp_q <= sp_d;
    phase2_q <= phase2_d;
  end

  assign valid_o        = (state_q == StOut);
  assign region_valid_o = !zero_q;
  assign region_x_o     = zero_q ? '0 : x_q;
  assign region_y_o     = zero_q ? '0 : y_q;
  assign region_w_o     = zero_q ? '0 : w_q;
  assign region_h_o     = zero_q ? '0 : h_q;
endmodule

// ----- hw/rtl/crc_checker.sv -----
// Port-level assertions for the crop region calculator, with bind.
`timescale 1ns / 1ps
module crc_assertions (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic                        result_valid_o,
  input logic [crc_pkg::DimBits-1:0] region_x_o,
  input logic [crc_pkg::DimBits-1:0] region_w_o,
  input logic [crc_pkg::DimBits-1:0] region_h_o,
  input logic                        region_valid_o
);
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("result held two cycles");
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !region_valid_o) |->
      (region_x_o == '0 && region_w_o == '0 && region_h_o == '0))
    else $error("invalid region not cleared");
  a_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && region_valid_o) |-> (region_w_o != '0 && region_h_o != '0))
    else $error("valid region has zero size");
  a_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !result_valid_o) else $error("result right after reset");
  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> !$isunknown(busy)) else $error("busy unknown");
endmodule

bind crop_region_calculator crc_assertions u_crc_checker (.*);

// ----- dv/crc_checker.sv -----
// Checker of the crop region calculator: predicts each region and compares results.
`timescale 1ns / 1ps
module crc_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        busy_i,
  input  logic [crc_pkg::DimBits-1:0] source_width_i,
  input  logic [crc_pkg::DimBits-1:0] source_height_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [1:0]                  cfg_index_i,
  input  logic [crc_pkg::SkyBits-1:0] cfg_data_i,
  input  logic                        result_valid_i,
  input  logic [crc_pkg::DimBits-1:0] region_x_i,
  input  logic [crc_pkg::DimBits-1:0] region_y_i,
  input  logic [crc_pkg::DimBits-1:0] region_w_i,
  input  logic [crc_pkg::DimBits-1:0] region_h_i,
  input  logic                        region_valid_i,
  output int                          fail_count_o,
  output int                          pending_o,
  output int                          regions_seen_o
);
  import crc_pkg::*;

  typedef struct packed {
    logic [DimBits-1:0] x;
    logic [DimBits-1:0] y;
    logic [DimBits-1:0] w;
    logic [DimBits-1:0] h;
    logic               ok;
  } region_t;

  logic [DimBits-1:0] tgt_w, tgt_h;
  logic [SkyBits-1:0] sky;
  region_t            expected_regions[$];

  function automatic longint unsigned div_half_even(longint unsigned num,
                                                    longint unsigned den);
    longint unsigned q, r2;
    q  = num / den;
    r2 = (num % den) * 2;
    if (r2 > den || (r2 == den && q[0])) q++;
    return q;
  endfunction

  function automatic longint unsigned one_min(longint unsigned v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic region_t crop_region(longint unsigned sw, longint unsigned sh);
    longint unsigned tw, th, x, y, w, h, a, b, diff, top, nv;
    region_t r;
    tw = tgt_w;
    th = tgt_h;
    x  = 0;
    y  = 0;
    w  = sw;
    h  = sh;
    r  = '0;
    if (sw == 0 || sh == 0 || tw == 0 || th == 0) return r;
    a    = w * th;
    b    = tw * h;
    diff = (a > b) ? a - b : b - a;
    if (diff * TolInv >= h * th) begin
      if (a > b) begin
        nv = one_min(div_half_even(h * tw, th));
        x  = (w - nv) / 2;
        w  = nv;
      end else begin
        nv = one_min(div_half_even(w * th, tw));
        y  = (h - nv) / 2;
        h  = nv;
      end
    end
    top = div_half_even(h * sky, 64'd1 << SkyBits);
    if (top > h - 1) top = h - 1;
    y += top;
    h -= top;
    a = w * th;
    b = tw * h;
    if (a > b) begin
      nv = one_min(div_half_even(h * tw, th));
      x += (w - nv) / 2;
      w  = nv;
    end else if (a < b) begin
      nv = one_min(div_half_even(w * th, tw));
      y += h - nv;
      h  = nv;
    end
    r.x  = x[DimBits-1:0];
    r.y  = y[DimBits-1:0];
    r.w  = w[DimBits-1:0];
    r.h  = h[DimBits-1:0];
    r.ok = 1'b1;
    return r;
  endfunction

  assign pending_o = expected_regions.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    region_t e, got;
    if (!rst_ni) begin
      tgt_w          <= DimBits'(1);
      tgt_h          <= DimBits'(1);
      sky            <= '0;
      fail_count_o   <= 0;
      regions_seen_o <= 0;
      expected_regions.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CfgTargetW: tgt_w <= cfg_data_i[DimBits-1:0];
          CfgTargetH: tgt_h <= cfg_data_i[DimBits-1:0];
          CfgSky:     sky   <= cfg_data_i;
          default: ;
        endcase
      end
      if (start_i && !busy_i)
        expected_regions.push_back(crop_region(source_width_i, source_height_i));
      if (result_valid_i) begin
        got = '{region_x_i, region_y_i, region_w_i, region_h_i, region_valid_i};
        regions_seen_o <= regions_seen_o + 1;
        if (expected_regions.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected region transfer %p", got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = expected_regions.pop_front();
          if (e != got) begin
            if (fail_count_o < 10)
              $display("region mismatch: exp x%0d y%0d w%0d h%0d v%0d, got x%0d y%0d w%0d h%0d v%0d",
                       e.x, e.y, e.w, e.h, e.ok, got.x, got.y, got.w, got.h, got.ok);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

// ----- dv/tb_top.sv -----
// Testbench top of the crop region calculator: stimulus, configuration and verdict.
`timescale 1ns / 1ps
module tb_top;
  import crc_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [DimBits-1:0] source_width_i = '0, source_height_i = '0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i = '0;
  logic [SkyBits-1:0] cfg_data_i = '0;
  logic               result_valid_o, region_valid_o;
  logic [DimBits-1:0] region_x_o, region_y_o, region_w_o, region_h_o;
  int                 fail_count, pending, regions_seen;
  int                 frames_sent = 0;
  longint             cycle_count = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  crop_region_calculator u_top (.*);

  crc_checker u_chk (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy),
    .source_width_i, .source_height_i,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .result_valid_i(result_valid_o), .region_x_i(region_x_o), .region_y_i(region_y_o),
    .region_w_i(region_w_o), .region_h_i(region_h_o), .region_valid_i(region_valid_o),
    .fail_count_o(fail_count), .pending_o(pending), .regions_seen_o(regions_seen)
  );

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > 400000) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  task automatic drain();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [SkyBits-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic setup(logic [DimBits-1:0] tw, logic [DimBits-1:0] th,
                       logic [SkyBits-1:0] sf);
    drain();
    write_reg(CfgTargetW, SkyBits'(tw));
    write_reg(CfgTargetH, SkyBits'(th));
    write_reg(CfgSky, sf);
    @(posedge clk_i);
  endtask

  // one frame transfer; start is only lowered when no back-to-back frame follows
  task automatic send_frame(logic [DimBits-1:0] sw, logic [DimBits-1:0] sh, bit idle_ok);
    start           <= 1'b1;
    source_width_i  <= sw;
    source_height_i <= sh;
    do @(posedge clk_i); while (busy);
    frames_sent++;
    if (idle_ok && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
  endtask

  function automatic logic [DimBits-1:0] rand_dim();
    case ($urandom_range(0, 5))
      0:       return DimBits'($urandom_range(0, 3));
      1:       return 14'h3fff - DimBits'($urandom_range(0, 3));
      2:       return DimBits'($urandom_range(1, 64));
      default: return DimBits'($urandom);
    endcase
  endfunction

  initial begin
    logic [DimBits-1:0] tw, th;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset targets, zero dims, extremes
    send_frame(0, 5, 0);
    send_frame(5, 0, 0);
    send_frame(14'h3fff, 14'h3fff, 0);
    send_frame(1, 1, 0);
    send_frame(14'h3fff, 1, 0);
    send_frame(1, 14'h3fff, 0);
    start <= 1'b0;
    setup(640, 480, 16'h4000);
    send_frame(1920, 1080, 0);
    send_frame(1080, 1920, 0);
    send_frame(641, 480, 0);
    send_frame(14'h3fff, 1, 0);
    send_frame(1, 14'h3fff, 0);
    send_frame(14'h2aaa, 14'h1555, 0);
    start <= 1'b0;
    setup(14'h3fff, 1, 16'hffff);
    send_frame(100, 100, 0);
    send_frame(14'h3fff, 14'h3fff, 0);
    send_frame(1, 1, 0);
    start <= 1'b0;
    setup(0, 480, 0);
    send_frame(640, 480, 0);
    start <= 1'b0;
    setup(640, 0, 0);
    send_frame(640, 480, 0);
    start <= 1'b0;
    setup(1, 14'h3fff, 16'h8000);
    send_frame(100, 100, 0);
    send_frame(3, 14'h3fff, 0);
    start <= 1'b0;

    // random phases, each with fresh register settings
    for (int ph = 0; ph < 16; ph++) begin
      tw = ($urandom_range(0, 3) == 0) ? rand_dim() : DimBits'($urandom_range(1, 2048));
      th = ($urandom_range(0, 3) == 0) ? rand_dim() : DimBits'($urandom_range(1, 2048));
      setup(tw, th, (ph % 4 == 0) ? 16'hffff : (ph % 4 == 1) ? 16'h0 : 16'($urandom));
      for (int i = 0; i < 40; i++) begin
        send_frame(rand_dim(), rand_dim(), ph < 14);
        if (ph == 5 && i == 20) begin
          start <= 1'b0;
          @(posedge clk_i);
          while (pending != 0) @(posedge clk_i);
        end
      end
      start <= 1'b0;
    end

    drain();
    $display("%0d frames sent, %0d regions checked over directed and random target setups",
             frames_sent, regions_seen);
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule
